// File: hdl/tdpt_pkg.sv
// Types and constants shared by the trial-division prime test core.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package tdpt_pkg;

	localparam int NUMBER_W = 16;
	localparam int COUNT_W  = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

	// request transaction payload
	typedef struct packed {
		logic                mode;
		logic [NUMBER_W-1:0] number;
	} tdpt_req_t;

	// response transaction payload
	typedef struct packed {
		logic               is_prime;
		logic [COUNT_W-1:0] prime_count;
	} tdpt_rsp_t;

	// status from the remainder unit back to the sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} tdpt_rem_stat_t;

endpackage

`default_nettype wire

// File: hdl/tdpt_rem_unit.sv
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg for the status struct.
`default_nettype none

module tdpt_rem_unit #(
	parameter int W = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [W-1:0]            dividend,
	input  wire logic [W-1:0]            divisor,
	output tdpt_pkg::tdpt_rem_stat_t     stat
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  rem_q;

	logic [W:0]    trial;
	logic [W-1:0]  rem_next;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[W-1:0];
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(W - 1);
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_next;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					zero_q <= (rem_next == '0);
				end else begin
					done_q <= 1'b0;
					cnt_q  <= cnt_q - 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

	// a new division never starts over one in flight
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit restarted while busy");

	// completion only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("remainder done without a division in flight");

endmodule

`default_nettype wire

// File: hdl/trial_division_prime_test_core.sv
// Trial-division prime test core: one request gives one response. Mode 0 tests
// whether number is prime; mode 1 counts the primes in 2..number and also reports
// whether number itself is prime. Only the low NUM_BITS bits of number are used.
// Each trial division runs on one shared remainder unit that retires one bit per
// cycle; a candidate is divided by two, three and so on while the divisor squared
// does not exceed it, stopping early when a factor turns up. A mode 1 request
// repeats this for every candidate 2..number. The request side stalls for the
// whole computation; the response register lets the next request enter while a
// response still waits. Depends on tdpt_pkg and tdpt_rem_unit.
`default_nettype none

module trial_division_prime_test_core #(
	parameter int NUM_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire tdpt_pkg::tdpt_req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output tdpt_pkg::tdpt_rsp_t rsp
);

	localparam int N    = NUM_BITS;
	localparam int SQ_W = NUM_BITS + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_TRY,
		ST_WAIT,
		ST_NEXT,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic                            mode_q;
	logic [N-1:0]                    limit_q;
	logic [N-1:0]                    cand_q;
	logic [N-1:0]                    div_q;
	logic [SQ_W-1:0]                 sq_q;
	logic [tdpt_pkg::COUNT_W-1:0]    count_q;
	logic                            prime_q;
	logic                            rsp_valid_q;
	tdpt_pkg::tdpt_rsp_t             rsp_q;

	logic                            req_take;
	logic [N-1:0]                    num_n;
	logic                            rem_start;
	tdpt_pkg::tdpt_rem_stat_t        rem_stat;

	assign num_n     = N'(req.number);
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rem_start = (state_q == ST_TRY) && (sq_q <= SQ_W'(cand_q));

	// shared remainder unit
	tdpt_rem_unit #(
		.W (N)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cand_q),
		.divisor  (div_q),
		.stat     (rem_stat)
	);

	// sequencer over candidates and divisors, plus response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			limit_q     <= '0;
			cand_q      <= '0;
			div_q       <= '0;
			sq_q        <= '0;
			count_q     <= '0;
			prime_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						mode_q  <= req.mode;
						limit_q <= num_n;
						count_q <= '0;
						cand_q  <= req.mode ? N'(2) : num_n;
						state_q <= ST_CAND;
					end
				end
				ST_CAND: begin
					if (mode_q && (cand_q > limit_q)) begin
						// count limit below two: nothing to test
						prime_q <= 1'b0;
						state_q <= ST_FINISH;
					end else if (cand_q < N'(2)) begin
						prime_q <= 1'b0;
						state_q <= ST_NEXT;
					end else begin
						div_q   <= N'(2);
						sq_q    <= SQ_W'(4);
						state_q <= ST_TRY;
					end
				end
				ST_TRY: begin
					if (rem_start) begin
						state_q <= ST_WAIT;
					end else begin
						// divisor squared passed the candidate
						prime_q <= 1'b1;
						state_q <= ST_NEXT;
					end
				end
				ST_WAIT: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							prime_q <= 1'b0;
							state_q <= ST_NEXT;
						end else begin
							// (d+1)^2 = d^2 + 2d + 1
							sq_q    <= sq_q + SQ_W'({div_q, 1'b1});
							div_q   <= div_q + 1'b1;
							state_q <= ST_TRY;
						end
					end
				end
				ST_NEXT: begin
					if (mode_q) begin
						if (prime_q && (count_q < tdpt_pkg::COUNT_MAX)) begin
							count_q <= count_q + 1'b1;
						end
						if (cand_q == limit_q) begin
							state_q <= ST_FINISH;
						end else begin
							cand_q  <= cand_q + 1'b1;
							state_q <= ST_CAND;
						end
					end else begin
						count_q <= tdpt_pkg::COUNT_W'(prime_q);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.is_prime    <= prime_q;
						rsp_q.prime_count <= count_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a division is only in flight while the divisor square fits the candidate
	a_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (sq_q <= SQ_W'(cand_q)))
		else $error("divisor square exceeds candidate during division");

	// trial divisors start at two
	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRY || state_q == ST_WAIT) |-> (div_q >= N'(2)))
		else $error("trial divisor below two");

	// a single-number test reports a count of zero or one
	a_mode0_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !mode_q) |-> (count_q == tdpt_pkg::COUNT_W'(prime_q)))
		else $error("single test count differs from prime flag");

endmodule

`default_nettype wire

// File: tb/sv/trial_division_prime_test_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for trial_division_prime_test_core: prime tests and prime
// counts are checked against an in-bench trial-division predictor.
// Depends on tdpt_pkg and the core RTL in hdl/.

module trial_division_prime_test_core_tb;

	localparam int NUMBER_W     = tdpt_pkg::NUMBER_W;
	localparam int COUNT_W      = tdpt_pkg::COUNT_W;
	localparam int NUM_BITS     = 16;
	localparam int RANDOM_ITEMS = 112;
	localparam int IDLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 3000;

	localparam logic MODE_TEST  = 1'b0;
	localparam logic MODE_COUNT = 1'b1;

	typedef struct {
		tdpt_pkg::tdpt_req_t req;
		tdpt_pkg::tdpt_rsp_t rsp;
	} prime_answer_t;

	// scoreboard: predicts each answer on request acceptance, checks responses in order
	class prime_scoreboard;
		prime_answer_t       answer_q[$];
		int unsigned         errors;
		int unsigned         checked;
		int unsigned         primes_seen;
		logic [COUNT_W-1:0]  max_count = '0;
		// model counterparts of the core's working registers
		logic [NUMBER_W-1:0] candidate;
		logic [NUMBER_W-1:0] trial_divisor;
		logic [NUMBER_W-1:0] partial_remainder;
		logic [COUNT_W-1:0]  running_count;
		logic                composite_seen;

		// trial division with exact remainders, stopping at a factor or once d*d exceeds n
		function bit divides_out(int unsigned n);
			int unsigned d;
			bit          comp;
			comp = 1'b0;
			candidate = NUMBER_W'(n);
			if (n < 2) begin
				trial_divisor = '0;
				partial_remainder = '0;
				composite_seen = 1'b1;
				return 1'b0;
			end
			for (d = 2; d * d <= n && !comp; d++) begin
				trial_divisor = NUMBER_W'(d);
				partial_remainder = NUMBER_W'(n % d);
				if (n % d == 0)
					comp = 1'b1;
			end
			composite_seen = comp;
			return !comp;
		endfunction

		function tdpt_pkg::tdpt_rsp_t predict_answer(tdpt_pkg::tdpt_req_t item);
			int unsigned         n;
			int unsigned         c;
			int unsigned         acc;
			bit                  p;
			tdpt_pkg::tdpt_rsp_t r;
			n = int'(item.number) & ((32'd1 << NUM_BITS) - 1);
			acc = 0;
			if (item.mode == MODE_COUNT) begin
				for (c = 2; c <= n; c++) begin
					if (divides_out(c) && acc < tdpt_pkg::COUNT_MAX)
						acc++;
					running_count = COUNT_W'(acc);
				end
				p = divides_out(n);
			end else begin
				p = divides_out(n);
				acc = p ? 1 : 0;
			end
			running_count = COUNT_W'(acc);
			r.is_prime = p;
			r.prime_count = COUNT_W'(acc);
			return r;
		endfunction

		function void note_request(tdpt_pkg::tdpt_req_t item);
			prime_answer_t a;
			a.req = item;
			a.rsp = predict_answer(item);
			answer_q.push_back(a);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_response(tdpt_pkg::tdpt_rsp_t got);
			prime_answer_t a;
			if (answer_q.size() == 0) begin
				report($sformatf("response with nothing pending: is_prime=%0d prime_count=%0d",
					got.is_prime, got.prime_count));
				return;
			end
			a = answer_q.pop_front();
			checked++;
			if (got.is_prime !== a.rsp.is_prime)
				report($sformatf("mode=%0d number=%0d is_prime got %0d want %0d",
					a.req.mode, a.req.number, got.is_prime, a.rsp.is_prime));
			if (got.prime_count !== a.rsp.prime_count)
				report($sformatf("mode=%0d number=%0d prime_count got %0d want %0d",
					a.req.mode, a.req.number, got.prime_count, a.rsp.prime_count));
			if (a.rsp.is_prime)
				primes_seen++;
			if (a.rsp.prime_count > max_count)
				max_count = a.rsp.prime_count;
		endtask

		function int pending();
			return answer_q.size();
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	tdpt_pkg::tdpt_req_t req       = '0;
	logic                req_stall;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	tdpt_pkg::tdpt_rsp_t rsp;

	int req_idle_pct  = 0;
	int rsp_stall_pct = 0;
	int hold_request  = 0;
	int tests_sent    = 0;
	int counts_sent   = 0;

	prime_scoreboard sb = new();

	trial_division_prime_test_core #(
		.NUM_BITS(NUM_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// response side: check accepted transactions, then pick next stall
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_valid && !rsp_stall)
					sb.check_response(rsp);
				if (hold_request > 0) begin
					hold_left = hold_request;
					hold_request = 0;
				end
				if (hold_left > 0) begin
					hold_left--;
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
				end
			end
		end
	end

	// watchdog: too long without any transaction on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
		$display("trial_division_prime_test_core regression: fail");
		$finish;
	end

	// offer one request, with random idle cycles ahead of it, until accepted
	task send_request(input logic mode, input logic [NUMBER_W-1:0] number);
		tdpt_pkg::tdpt_req_t item;
		item.mode = mode;
		item.number = number;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
		if (mode == MODE_COUNT)
			counts_sent++;
		else
			tests_sent++;
	endtask

	task wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// random mix: mostly single tests, count limits kept small to bound run time
	task send_random();
		logic [NUMBER_W-1:0] n;
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(9) == 0)
				n = NUMBER_W'($urandom_range(700, 200));
			else
				n = NUMBER_W'($urandom_range(200));
			send_request(MODE_COUNT, n);
		end else begin
			case ($urandom_range(2))
				0: n = NUMBER_W'($urandom);
				1: n = NUMBER_W'($urandom_range(255));
				default: n = NUMBER_W'($urandom) | 16'h0001;
			endcase
			send_request(MODE_TEST, n);
		end
	endtask

	initial begin
		int phase;
		int k;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: below two, two, small squares, field extremes, largest primes, then counts
		send_request(MODE_TEST, 16'd0);
		send_request(MODE_TEST, 16'd1);
		send_request(MODE_TEST, 16'd2);
		send_request(MODE_TEST, 16'd3);
		send_request(MODE_TEST, 16'd4);
		send_request(MODE_TEST, 16'd9);
		send_request(MODE_TEST, 16'd25);
		send_request(MODE_TEST, 16'hffff);
		send_request(MODE_TEST, 16'hfffe);
		send_request(MODE_TEST, 16'd65521);
		send_request(MODE_TEST, 16'h8000);
		send_request(MODE_TEST, 16'd32749);
		send_request(MODE_TEST, 16'h5555);
		send_request(MODE_COUNT, 16'd0);
		send_request(MODE_COUNT, 16'd1);
		send_request(MODE_COUNT, 16'd2);
		send_request(MODE_COUNT, 16'd3);
		send_request(MODE_COUNT, 16'd4);
		send_request(MODE_COUNT, 16'd10);
		send_request(MODE_COUNT, 16'd100);
		send_request(MODE_COUNT, 16'd1023);

		// back-pressure: response side held off while quick requests keep coming
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 8; k++)
			send_request(MODE_TEST, NUMBER_W'($urandom_range(40)));
		wait_drained();

		// random phases with different idle and stall mixes
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin req_idle_pct = 50; rsp_stall_pct = 0;  end
				2: begin req_idle_pct = 0;  rsp_stall_pct = 50; end
				default: begin req_idle_pct = 14; rsp_stall_pct = 14; end
			endcase
			for (k = 0; k < RANDOM_ITEMS / 4; k++)
				send_random();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d prime tests and %0d prime counts, %0d responses checked",
			tests_sent, counts_sent, sb.checked);
		$display("%0d prime answers seen, largest count %0d, %0d mismatches",
			sb.primes_seen, sb.max_count, sb.errors);
		if (sb.errors == 0)
			$display("trial_division_prime_test_core regression: pass");
		else
			$display("trial_division_prime_test_core regression: fail");
		$finish;
	end

endmodule
